FILE: rtl/srcc_pkg.sv
`timescale 1ns / 1ps

package srcc_pkg;

  localparam int MAX_IGNORED_DEF = 8;
  localparam int COORD_BITS_DEF  = 10;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int GLYPH_W         = 8;
  localparam int COUNT_W         = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OWN_LEFT      = 3'd0,
    REG_OWN_TOP       = 3'd1,
    REG_OWN_WIDTH     = 3'd2,
    REG_OWN_HEIGHT    = 3'd3,
    REG_OTHER_LEFT    = 3'd4,
    REG_OTHER_TOP     = 3'd5,
    REG_IGNORED_CHARS = 3'd6,
    REG_IGNORED_COUNT = 3'd7
  } reg_index_t;

endpackage

FILE: rtl/srcc_cfg_regs.sv
`timescale 1ns / 1ps

module srcc_cfg_regs #(
  parameter int MAX_IGNORED = srcc_pkg::MAX_IGNORED_DEF,
  parameter int COORD_BITS  = srcc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [srcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [srcc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [COORD_BITS-1:0]                own_left,
  output logic [COORD_BITS-1:0]                own_top,
  output logic [COORD_BITS:0]                  own_width,
  output logic [COORD_BITS:0]                  own_height,
  output logic [COORD_BITS-1:0]                other_left,
  output logic [COORD_BITS-1:0]                other_top,
  output logic [srcc_pkg::GLYPH_W*MAX_IGNORED-1:0] ignored_chars,
  output logic [srcc_pkg::COUNT_W-1:0]         ignored_count
);

  localparam int CHARS_W = srcc_pkg::GLYPH_W * MAX_IGNORED;

  logic [COORD_BITS-1:0]        own_left_r, own_top_r, other_left_r, other_top_r;
  logic [COORD_BITS:0]          own_width_r, own_height_r;
  logic [CHARS_W-1:0]           ignored_chars_r;
  logic [srcc_pkg::COUNT_W-1:0] ignored_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_left_r      <= '0;
      own_top_r       <= '0;
      own_width_r     <= (COORD_BITS+1)'(1);
      own_height_r    <= (COORD_BITS+1)'(1);
      other_left_r    <= '0;
      other_top_r     <= '0;
      ignored_chars_r <= '0;
      ignored_count_r <= srcc_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (srcc_pkg::reg_index_t'(cfg_index))
        srcc_pkg::REG_OWN_LEFT:      own_left_r      <= cfg_wdata[COORD_BITS-1:0];
        srcc_pkg::REG_OWN_TOP:       own_top_r       <= cfg_wdata[COORD_BITS-1:0];
        srcc_pkg::REG_OWN_WIDTH:     own_width_r     <= cfg_wdata[COORD_BITS:0];
        srcc_pkg::REG_OWN_HEIGHT:    own_height_r    <= cfg_wdata[COORD_BITS:0];
        srcc_pkg::REG_OTHER_LEFT:    other_left_r    <= cfg_wdata[COORD_BITS-1:0];
        srcc_pkg::REG_OTHER_TOP:     other_top_r     <= cfg_wdata[COORD_BITS-1:0];
        srcc_pkg::REG_IGNORED_CHARS: ignored_chars_r <= cfg_wdata[CHARS_W-1:0];
        srcc_pkg::REG_IGNORED_COUNT:
          ignored_count_r <= cfg_wdata[srcc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign own_left      = own_left_r;
  assign own_top       = own_top_r;
  assign own_width     = own_width_r;
  assign own_height    = own_height_r;
  assign other_left    = other_left_r;
  assign other_top     = other_top_r;
  assign ignored_chars = ignored_chars_r;
  assign ignored_count = ignored_count_r;

endmodule

FILE: rtl/srcc_cell_test.sv
`timescale 1ns / 1ps

module srcc_cell_test #(
  parameter int MAX_IGNORED = srcc_pkg::MAX_IGNORED_DEF,
  parameter int COORD_BITS  = srcc_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]                    own_left,
  input  logic [COORD_BITS-1:0]                    own_top,
  input  logic [COORD_BITS:0]                      own_width,
  input  logic [COORD_BITS:0]                      own_height,
  input  logic [COORD_BITS-1:0]                    other_left,
  input  logic [COORD_BITS-1:0]                    other_top,
  input  logic [srcc_pkg::GLYPH_W*MAX_IGNORED-1:0] ignored_chars,
  input  logic [srcc_pkg::COUNT_W-1:0]             ignored_count,
  input  logic [COORD_BITS-1:0]                    cell_col,
  input  logic [COORD_BITS-1:0]                    cell_row,
  input  logic [srcc_pkg::GLYPH_W-1:0]             cell_glyph,
  output logic                                     hit
);

  localparam int SUM_W = COORD_BITS + 2;

  logic [SUM_W-1:0]       sx, sy, x0, y0, x_end, y_end;
  logic                   in_rect;
  logic [MAX_IGNORED-1:0] match;
  logic                   ignored;

  always_comb begin
    sx    = SUM_W'(other_left) + SUM_W'(cell_col);
    sy    = SUM_W'(other_top) + SUM_W'(cell_row);
    x0    = SUM_W'(own_left);
    y0    = SUM_W'(own_top);
    x_end = x0 + SUM_W'(own_width);
    y_end = y0 + SUM_W'(own_height);
    in_rect = (sx >= x0) && (sx < x_end) && (sy >= y0) && (sy < y_end);
  end

  // A slot counts only when its index is below the programmed count.
  always_comb begin
    for (int k = 0; k < MAX_IGNORED; k++) begin
      match[k] = (ignored_count > srcc_pkg::COUNT_W'(k)) &&
                 (ignored_chars[k*srcc_pkg::GLYPH_W +: srcc_pkg::GLYPH_W] == cell_glyph);
    end
    ignored = |match;
  end

  assign hit = in_rect && !ignored;

endmodule

FILE: rtl/sprite_rect_and_cell_collision.sv
`timescale 1ns / 1ps

// Cell-level sprite collision check. The other sprite's frame streams in one
// cell per clock; each accepted item is registered, tested against this
// sprite's rectangle and the ignored characters, and folded into a sticky
// hit flag. The item marked as the final cell produces one result that is
// registered first in the cell stage and then in the output register, and the
// flag clears for the next frame. The input side stalls only while a
// finished result waits on the output and the next final cell needs the
// output register; otherwise one item is taken in every cycle. The user must
// write the configuration registers only while no cells are in flight; the
// block itself does not enforce this. No clearing pass is needed after reset.
module sprite_rect_and_cell_collision #(
  parameter int MAX_IGNORED = srcc_pkg::MAX_IGNORED_DEF,
  parameter int COORD_BITS  = srcc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_BITS-1:0]            in_cell_col,
  input  logic [COORD_BITS-1:0]            in_cell_row,
  input  logic [srcc_pkg::GLYPH_W-1:0]     in_cell_glyph,
  input  logic                             in_final_cell,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_collided
);

  logic [COORD_BITS-1:0]                    own_left, own_top, other_left, other_top;
  logic [COORD_BITS:0]                      own_width, own_height;
  logic [srcc_pkg::GLYPH_W*MAX_IGNORED-1:0] ignored_chars;
  logic [srcc_pkg::COUNT_W-1:0]             ignored_count;

  logic                         s1_valid_r, s1_valid_nxt;
  logic [COORD_BITS-1:0]        s1_col_r, s1_row_r;
  logic [srcc_pkg::GLYPH_W-1:0] s1_glyph_r;
  logic                         s1_final_r;
  logic                         hit_seen_r, hit_seen_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_collided_r, out_collided_nxt;
  logic                         hit, in_take, s1_adv;

  srcc_cfg_regs #(
    .MAX_IGNORED (MAX_IGNORED),
    .COORD_BITS  (COORD_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .own_left      (own_left),
    .own_top       (own_top),
    .own_width     (own_width),
    .own_height    (own_height),
    .other_left    (other_left),
    .other_top     (other_top),
    .ignored_chars (ignored_chars),
    .ignored_count (ignored_count)
  );

  srcc_cell_test #(
    .MAX_IGNORED (MAX_IGNORED),
    .COORD_BITS  (COORD_BITS)
  ) u_test (
    .own_left      (own_left),
    .own_top       (own_top),
    .own_width     (own_width),
    .own_height    (own_height),
    .other_left    (other_left),
    .other_top     (other_top),
    .ignored_chars (ignored_chars),
    .ignored_count (ignored_count),
    .cell_col      (s1_col_r),
    .cell_row      (s1_row_r),
    .cell_glyph    (s1_glyph_r),
    .hit           (hit)
  );

  assign s1_adv   = s1_valid_r && (!s1_final_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt     = s1_valid_r;
    hit_seen_nxt     = hit_seen_r;
    out_valid_nxt    = out_valid_r;
    out_collided_nxt = out_collided_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      if (s1_final_r) begin
        hit_seen_nxt     = 1'b0;
        out_valid_nxt    = 1'b1;
        out_collided_nxt = hit_seen_r || hit;
      end else begin
        hit_seen_nxt = hit_seen_r || hit;
      end
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      hit_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      hit_seen_r  <= hit_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_collided_r <= out_collided_nxt;
    if (in_take) begin
      s1_col_r   <= in_cell_col;
      s1_row_r   <= in_cell_row;
      s1_glyph_r <= in_cell_glyph;
      s1_final_r <= in_final_cell;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_collided = out_collided_r;

endmodule

FILE: rtl/srcc_checker.sv
`timescale 1ns / 1ps

module srcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_collided
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_collided))
    else $error("stalled result changed");

  // Leaving reset, the output is empty and the input side can take an item.
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // The input side only stalls behind a result that is waiting to be taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // An item that is offered while the output drains is always taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_ready |-> in_ready)
    else $error("item refused while output drains");

endmodule

bind sprite_rect_and_cell_collision srcc_checker u_srcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_collided (out_collided)
);

FILE: bench/sprite_rect_and_cell_collision_tb.sv
`timescale 1ns / 1ps

module sprite_rect_and_cell_collision_tb;

  typedef struct packed {
    logic [srcc_pkg::COORD_BITS_DEF-1:0] col;
    logic [srcc_pkg::COORD_BITS_DEF-1:0] row;
    logic [srcc_pkg::GLYPH_W-1:0]        glyph;
    logic                                last;
  } cell_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [srcc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [srcc_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic [srcc_pkg::COORD_BITS_DEF-1:0] in_cell_col;
  logic [srcc_pkg::COORD_BITS_DEF-1:0] in_cell_row;
  logic [srcc_pkg::GLYPH_W-1:0]        in_cell_glyph;
  logic                                in_final_cell;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_collided;

  // Shadow copy of the configuration registers and the sticky hit flag.
  logic [9:0]  own_left_q, own_top_q, other_left_q, other_top_q;
  logic [10:0] own_width_q, own_height_q;
  logic [63:0] ignored_chars_q;
  logic [3:0]  ignored_count_q;
  logic        hit_flag;

  logic [63:0] reg_plan [8];
  cell_t       cells_to_send [$];
  logic        collided_expected [$];
  cell_t       next_cell;
  cell_t       taken_cell;
  logic        in_taken;
  logic        want_collided;
  int          gap_pct;
  int          stall_pct;
  int          mismatches;

  sprite_rect_and_cell_collision dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic cell_hits(cell_t c);
    logic [11:0] sx, sy, x_end, y_end;
    int n;
    sx = {2'b00, other_left_q} + {2'b00, c.col};
    sy = {2'b00, other_top_q} + {2'b00, c.row};
    x_end = {2'b00, own_left_q} + {1'b0, own_width_q};
    y_end = {2'b00, own_top_q} + {1'b0, own_height_q};
    if (sx < {2'b00, own_left_q} || sx >= x_end) return 1'b0;
    if (sy < {2'b00, own_top_q} || sy >= y_end) return 1'b0;
    n = (int'(ignored_count_q) > srcc_pkg::MAX_IGNORED_DEF) ?
        srcc_pkg::MAX_IGNORED_DEF : int'(ignored_count_q);
    for (int k = 0; k < n; k++) begin
      if (ignored_chars_q[8*k +: 8] == c.glyph) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Picks a local coordinate whose screen position lands near an edge of this
  // sprite's span, falling back to a random one when that is out of reach.
  function automatic logic [9:0] aim(logic [9:0] origin, logic [10:0] size, logic [9:0] offset);
    int span, target;
    span = (size > 11'd60) ? 60 : int'(size);
    if ($urandom_range(1)) begin
      target = int'(origin) - 2 + int'($urandom_range(span + 3));
    end else begin
      target = int'(origin) + int'(size) - 2 + int'($urandom_range(3));
    end
    target = target - int'(offset);
    if (target >= 0 && target < 1024) return target[9:0];
    return 10'($urandom_range(1023));
  endfunction

  function automatic cell_t aimed_cell();
    cell_t c;
    int k;
    c.col = aim(own_left_q, own_width_q, other_left_q);
    c.row = aim(own_top_q, own_height_q, other_top_q);
    k = $urandom_range(7);
    if ($urandom_range(2) == 0) begin
      c.glyph = ignored_chars_q[8*k +: 8];
    end else begin
      c.glyph = 8'($urandom_range(255));
    end
    c.last = 1'b0;
    return c;
  endfunction

  task automatic push_cell(int col, int row, int glyph, logic last);
    cell_t c;
    c.col = 10'(col);
    c.row = 10'(row);
    c.glyph = 8'(glyph);
    c.last = last;
    cells_to_send.push_back(c);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (cells_to_send.size() != 0 || in_valid || collided_expected.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= srcc_pkg::CFG_INDEX_W'(i);
      cfg_wdata <= reg_plan[i];
      case (srcc_pkg::reg_index_t'(i))
        srcc_pkg::REG_OWN_LEFT:      own_left_q = reg_plan[i][9:0];
        srcc_pkg::REG_OWN_TOP:       own_top_q = reg_plan[i][9:0];
        srcc_pkg::REG_OWN_WIDTH:     own_width_q = reg_plan[i][10:0];
        srcc_pkg::REG_OWN_HEIGHT:    own_height_q = reg_plan[i][10:0];
        srcc_pkg::REG_OTHER_LEFT:    other_left_q = reg_plan[i][9:0];
        srcc_pkg::REG_OTHER_TOP:     other_top_q = reg_plan[i][9:0];
        srcc_pkg::REG_IGNORED_CHARS: ignored_chars_q = reg_plan[i];
        srcc_pkg::REG_IGNORED_COUNT: ignored_count_q = reg_plan[i][3:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(int ol, int ot, int ow, int oh, int xl, int xt,
                           logic [63:0] chars, int cnt);
    reg_plan[srcc_pkg::REG_OWN_LEFT] = 64'(ol);
    reg_plan[srcc_pkg::REG_OWN_TOP] = 64'(ot);
    reg_plan[srcc_pkg::REG_OWN_WIDTH] = 64'(ow);
    reg_plan[srcc_pkg::REG_OWN_HEIGHT] = 64'(oh);
    reg_plan[srcc_pkg::REG_OTHER_LEFT] = 64'(xl);
    reg_plan[srcc_pkg::REG_OTHER_TOP] = 64'(xt);
    reg_plan[srcc_pkg::REG_IGNORED_CHARS] = chars;
    reg_plan[srcc_pkg::REG_IGNORED_COUNT] = 64'(cnt);
    program_regs();
  endtask

  task automatic randomize_regs();
    for (int i = 0; i < 6; i++) begin
      if (i == srcc_pkg::REG_OWN_WIDTH || i == srcc_pkg::REG_OWN_HEIGHT) begin
        case ($urandom_range(9))
          0: reg_plan[i] = 64'd0;
          1: reg_plan[i] = 64'd1024;
          2: reg_plan[i] = 64'd2047;
          3: reg_plan[i] = 64'd1;
          default: reg_plan[i] = 64'($urandom_range(48, 1));
        endcase
      end else begin
        case ($urandom_range(9))
          0: reg_plan[i] = 64'd0;
          1: reg_plan[i] = 64'd1023;
          default: reg_plan[i] = 64'($urandom_range(1023));
        endcase
      end
    end
    reg_plan[srcc_pkg::REG_IGNORED_CHARS] = {$urandom, $urandom};
    case ($urandom_range(5))
      0: reg_plan[srcc_pkg::REG_IGNORED_COUNT] = 64'd0;
      1: reg_plan[srcc_pkg::REG_IGNORED_COUNT] = 64'($urandom_range(15, 9));
      default: reg_plan[srcc_pkg::REG_IGNORED_COUNT] = 64'($urandom_range(8, 1));
    endcase
    // Bits above a register's width must be dropped by the block.
    for (int i = 0; i < 8; i++) begin
      if (i != srcc_pkg::REG_IGNORED_CHARS && $urandom_range(7) == 0) begin
        reg_plan[i][63:12] = {$urandom, 20'($urandom)};
      end
    end
    program_regs();
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (cells_to_send.size() > 0 && int'($urandom_range(99)) >= gap_pct) begin
        next_cell = cells_to_send.pop_front();
        in_valid <= 1'b1;
        in_cell_col <= next_cell.col;
        in_cell_row <= next_cell.row;
        in_cell_glyph <= next_cell.glyph;
        in_final_cell <= next_cell.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= (int'($urandom_range(99)) >= stall_pct);
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      taken_cell = {in_cell_col, in_cell_row, in_cell_glyph, in_final_cell};
      if (cell_hits(taken_cell)) hit_flag = 1'b1;
      if (taken_cell.last) begin
        collided_expected.push_back(hit_flag);
        hit_flag = 1'b0;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (collided_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, collided=%0b", out_collided));
      end else begin
        want_collided = collided_expected.pop_front();
        if (out_collided !== want_collided) begin
          flag_mismatch($sformatf("collided: expected %0b, got %0b",
                                  want_collided, out_collided));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int quota;
    int len;
    cell_t c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cell_col = '0;
    in_cell_row = '0;
    in_cell_glyph = '0;
    in_final_cell = 1'b0;
    out_ready = 1'b0;
    in_taken = 1'b0;
    hit_flag = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    own_left_q = '0;
    own_top_q = '0;
    own_width_q = 11'd1;
    own_height_q = 11'd1;
    other_left_q = '0;
    other_top_q = '0;
    ignored_chars_q = '0;
    ignored_count_q = 4'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: a one-cell rectangle at the origin ignoring 0x00.
    push_cell(0, 0, 8'h00, 1'b1);
    push_cell(0, 0, 8'h41, 1'b1);
    push_cell(1, 0, 8'h41, 1'b1);
    push_cell(0, 0, 8'h41, 1'b0);
    push_cell(5, 5, 8'h41, 1'b1);
    push_cell(1023, 1023, 8'hFF, 1'b1);
    wait_quiet();

    // Rectangle reaching past the largest coordinate, with an empty ignore set.
    load_regs(1023, 1023, 2047, 2047, 1023, 1023, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_cell(1023, 1023, 8'hFF, 1'b1);
    push_cell(0, 0, 8'h00, 1'b1);
    wait_quiet();

    // Empty rectangles.
    load_regs(10, 20, 0, 5, 0, 0, 64'h0, 1);
    push_cell(10, 20, 8'h41, 1'b1);
    wait_quiet();
    load_regs(10, 20, 5, 0, 0, 0, 64'h0, 1);
    push_cell(10, 20, 8'h41, 1'b1);
    wait_quiet();

    // An ignore count above the maximum acts as the maximum.
    load_regs(0, 0, 1024, 1024, 0, 0, 64'h0807_0605_0403_0201, 15);
    push_cell(3, 4, 8'h08, 1'b1);
    push_cell(3, 4, 8'h09, 1'b1);
    wait_quiet();
    load_regs(0, 0, 1024, 1024, 0, 0, 64'h0807_0605_0403_0201, 3);
    push_cell(1023, 1023, 8'h04, 1'b1);
    push_cell(1023, 0, 8'h03, 1'b1);
    wait_quiet();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        randomize_regs();
        quota = 0;
        while (quota < 115) begin
          if ($urandom_range(7) == 0) begin
            c = cell_t'($bits(cell_t)'($urandom));
            c.last = ($urandom_range(3) == 0);
            cells_to_send.push_back(c);
            quota++;
          end else begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
              c = aimed_cell();
              c.last = (i == len - 1);
              cells_to_send.push_back(c);
            end
            quota += len;
          end
        end
        wait_quiet();
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
